@@ rtl/sm3_pkg.sv @@
// SM3 engine shared types, constants and round functions
package sm3_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  byte_count;
		logic        final_word;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
		logic        length_error;
	} out_word_t;

	// front-to-back queue entry: one block word, plus end-of-message and length-error flags
	typedef struct packed {
		logic [31:0] data;
		logic        msg_end;
		logic        len_err;
	} blk_word_t;

	localparam logic [255:0] IV = {
		32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
		32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
	};
	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h9d8a7a87;
	localparam logic [31:0] PAD_BIT = 32'h80000000;

	function automatic logic [31:0] rol(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rol(x, 5'd9) ^ rol(x, 5'd17);
	endfunction

	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rol(x, 5'd15) ^ rol(x, 5'd23);
	endfunction

endpackage

@@ rtl/sm3_hash_engine.sv @@
// SM3 hash engine top level
//  channel | dir | payload            | handshake
//  in      | in  | sm3_pkg::in_word_t | in_valid / in_stall
//  out     | out | sm3_pkg::out_word_t| out_valid / out_stall
// Each 16-word block is loaded word by word into the core, then takes 64
// compression rounds, one round per cycle in the core.
// The queue fills during the rounds, then the front stalls.
// Final word adds padding and length words (1-2 blocks) then 8 digest words.
// Reset clears all control state and loads the initial vector.
// The front and core stall independently through the word queue.
module sm3_hash_engine #(
	parameter int QueueDepth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sm3_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sm3_pkg::out_word_t out_data
);

	logic               fq_valid, fq_full, qc_valid, qc_take;
	sm3_pkg::blk_word_t fq_data, qc_data;

	sm3_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid(fq_valid), .q_full(fq_full), .q_data(fq_data)
	);

	sm3_fifo #(.Depth(QueueDepth)) u_fifo (
		.clk, .arst_n,
		.wr_valid(fq_valid), .full(fq_full), .wr_data(fq_data),
		.rd_valid(qc_valid), .rd_take(qc_take), .rd_data(qc_data)
	);

	sm3_core u_core (
		.clk, .arst_n,
		.q_valid(qc_valid), .q_take(qc_take), .q_data(qc_data),
		.out_valid, .out_stall, .out_data
	);

endmodule

@@ rtl/sm3_front.sv @@
// SM3 front end: bit counting, padding and length words into the queue
module sm3_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sm3_pkg::in_word_t  in_data,
	output logic               q_valid,
	input  logic               q_full,
	output sm3_pkg::blk_word_t q_data
);

	typedef enum logic [2:0] {F_DATA, F_PAD, F_ZERO, F_LENH, F_LENL} fst_t;

	fst_t        state_q;
	logic [3:0]  pos_q;
	logic [63:0] len_q;
	logic        ovf_q;
	logic [31:0] pad_q;

	logic [2:0]  cnt;
	logic [31:0] keep;
	logic [64:0] len_sum;
	logic [31:0] pad_word;

	always_comb begin
		cnt = (in_data.byte_count > 3'd4) ? 3'd4 : in_data.byte_count;
		if (!in_data.final_word)
			len_sum = {1'b0, len_q} + 65'd32;
		else
			len_sum = {1'b0, len_q} + {59'd0, cnt, 3'd0};
		keep = 32'hFFFFFFFF << (6'd32 - {cnt, 3'd0});
		if (cnt == 3'd0)
			keep = 32'd0;
		pad_word = (in_data.message_word & keep) | (sm3_pkg::PAD_BIT >> {cnt, 3'd0});
	end

	assign in_stall = (state_q != F_DATA) || q_full;

	always_comb begin
		q_valid = 1'b0;
		q_data = '0;
		q_data.len_err = ovf_q;
		case (state_q)
			F_DATA: begin
				q_valid = in_valid && !(in_data.final_word && cnt != 3'd4);
				q_data.data = in_data.message_word;
			end
			F_PAD: begin
				q_valid = 1'b1;
				q_data.data = pad_q;
			end
			F_ZERO: q_valid = 1'b1;
			F_LENH: begin
				q_valid = 1'b1;
				q_data.data = len_q[63:32];
			end
			F_LENL: begin
				q_valid = 1'b1;
				q_data.data = len_q[31:0];
				q_data.msg_end = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_DATA;
			pos_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
			pad_q <= '0;
		end else if (!q_full) begin
			case (state_q)
				F_DATA: if (in_valid) begin
					len_q <= len_sum[63:0];
					if (len_sum[64])
						ovf_q <= 1'b1;
					if (!in_data.final_word) begin
						pos_q <= pos_q + 4'd1;
					end else begin
						pad_q <= (cnt == 3'd4) ? sm3_pkg::PAD_BIT : pad_word;
						if (cnt == 3'd4)
							pos_q <= pos_q + 4'd1;
						state_q <= F_PAD;
					end
				end
				F_PAD: begin
					pos_q <= pos_q + 4'd1;
					state_q <= (pos_q == 4'd13) ? F_LENH : F_ZERO;
				end
				F_ZERO: begin
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'd13)
						state_q <= F_LENH;
				end
				F_LENH: begin
					pos_q <= pos_q + 4'd1;
					state_q <= F_LENL;
				end
				F_LENL: begin
					pos_q <= '0;
					len_q <= '0;
					ovf_q <= 1'b0;
					state_q <= F_DATA;
				end
				default: state_q <= F_DATA;
			endcase
		end
	end

endmodule

@@ rtl/sm3_fifo.sv @@
// SM3 short word queue between front end and compression core
module sm3_fifo #(
	parameter int Depth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               full,
	input  sm3_pkg::blk_word_t wr_data,
	output logic               rd_valid,
	input  logic               rd_take,
	output sm3_pkg::blk_word_t rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	sm3_pkg::blk_word_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign full = (cnt_q == (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && !full;
	assign rd = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

endmodule

@@ rtl/sm3_core.sv @@
// SM3 back end: block gather, 64-round compression, digest output
module sm3_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  sm3_pkg::blk_word_t q_data,
	output logic               out_valid,
	input  logic               out_stall,
	output sm3_pkg::out_word_t out_data
);

	typedef enum logic [1:0] {C_LOAD, C_ROUND, C_OUT} cst_t;

	cst_t        state_q;
	logic [3:0]  wpos_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        end_q;
	logic        err_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] t_q;

	logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, wn;

	always_comb begin
		a12 = sm3_pkg::rol(a_q, 5'd12);
		ss1 = sm3_pkg::rol(a12 + e_q + t_q, 5'd7);
		ss2 = ss1 ^ a12;
		if (rnd_q < 6'd16) begin
			ffv = a_q ^ b_q ^ c_q;
			ggv = e_q ^ f_q ^ g_q;
		end else begin
			ffv = (a_q & b_q) | (a_q & c_q) | (b_q & c_q);
			ggv = (e_q & f_q) | (~e_q & g_q);
		end
		tt1 = ffv + d_q + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = ggv + h_q + ss1 + w_q[0];
		wn = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rol(w_q[13], 5'd15))
			^ sm3_pkg::rol(w_q[3], 5'd7) ^ w_q[10];
	end

	assign q_take = (state_q == C_LOAD);
	assign out_valid = (state_q == C_OUT);
	assign out_data.digest_word = v_q[oidx_q];
	assign out_data.word_index = oidx_q;
	assign out_data.last_word = (oidx_q == 3'd7);
	assign out_data.length_error = err_q;

	always_ff @(posedge clk) begin
		if (state_q == C_LOAD && q_valid)
			w_q[wpos_q] <= q_data.data;
		else if (state_q == C_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_LOAD;
			wpos_q <= '0;
			rnd_q <= '0;
			oidx_q <= '0;
			end_q <= 1'b0;
			err_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				v_q[i] <= sm3_pkg::IV[255-32*i -: 32];
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= '0;
			t_q <= '0;
		end else begin
			case (state_q)
				C_LOAD: if (q_valid) begin
					wpos_q <= wpos_q + 4'd1;
					if (wpos_q == 4'd15) begin
						end_q <= q_data.msg_end;
						err_q <= q_data.len_err;
						{a_q, b_q, c_q, d_q} <= {v_q[0], v_q[1], v_q[2], v_q[3]};
						{e_q, f_q, g_q, h_q} <= {v_q[4], v_q[5], v_q[6], v_q[7]};
						t_q <= sm3_pkg::T_LOW;
						rnd_q <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					d_q <= c_q;
					c_q <= sm3_pkg::rol(b_q, 5'd9);
					b_q <= a_q;
					a_q <= tt1;
					h_q <= g_q;
					g_q <= sm3_pkg::rol(f_q, 5'd19);
					f_q <= e_q;
					e_q <= sm3_pkg::p0(tt2);
					t_q <= (rnd_q == 6'd15) ? sm3_pkg::T_HIGH : sm3_pkg::rol(t_q, 5'd1);
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						v_q[0] <= v_q[0] ^ tt1;
						v_q[1] <= v_q[1] ^ a_q;
						v_q[2] <= v_q[2] ^ sm3_pkg::rol(b_q, 5'd9);
						v_q[3] <= v_q[3] ^ c_q;
						v_q[4] <= v_q[4] ^ sm3_pkg::p0(tt2);
						v_q[5] <= v_q[5] ^ e_q;
						v_q[6] <= v_q[6] ^ sm3_pkg::rol(f_q, 5'd19);
						v_q[7] <= v_q[7] ^ g_q;
						oidx_q <= '0;
						state_q <= end_q ? C_OUT : C_LOAD;
					end
				end
				C_OUT: if (!out_stall) begin
					oidx_q <= oidx_q + 3'd1;
					if (oidx_q == 3'd7) begin
						for (int i = 0; i < 8; i++)
							v_q[i] <= sm3_pkg::IV[255-32*i -: 32];
						state_q <= C_LOAD;
					end
				end
				default: state_q <= C_LOAD;
			endcase
		end
	end

endmodule
